FILE: hdl/fps_pkg.sv
// Shared types, constants and state codes of the schedulability simulator.
package fps_pkg;
   localparam int MaxTasks = 16;
   localparam int IdxBits = $clog2(MaxTasks);
   localparam int CntBits = IdxBits + 1;
   localparam logic [31:0] TimeMax = 32'hFFFF_FFFF;

   localparam logic [1:0] ModeLoad = 2'd0;
   localparam logic [1:0] ModePeriod = 2'd1;
   localparam logic [1:0] ModeExec = 2'd2;
   localparam logic [1:0] ModeUtil = 2'd3;

   localparam logic [0:0] RegMode = 1'b0;
   localparam logic [0:0] RegHorizon = 1'b1;

   typedef struct packed {
      logic [31:0] task_period;
      logic [31:0] task_exec_time;
      logic [31:0] task_deadline;
      logic        last_task;
   } req_type;

   typedef struct packed {
      logic        schedulable;
      logic [31:0] end_time;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_LOAD, ST_SORT_RD, ST_SORT_MUL, ST_SORT_CMP, ST_INIT,
      ST_PICK, ST_RUN, ST_UPD, ST_DONE
   } state_type;
endpackage

FILE: hdl/fixed_priority_schedulability_sim.sv
// Top level: task loader, insertion sorter and event-driven scheduling simulator.
//
// Tasks are loaded one item per cycle while req_stall is low. The item that carries
// last_task starts the run: an insertion sort (mode 3 compares exec*period products
// through one 32x32 multiplier, two products per compare) then the simulation, where
// each scheduling event is one scan of the tasks that picks the job and the next
// release, ST_RUN that trims the step, and one scan that updates every task; a miss
// ends the update scan early. Total run time is data dependent: it grows with the
// sort compares and with the events up to the horizon. req_stall stays high from
// the last task until the result moves into the output register; a new set may
// load while that result waits.
module fixed_priority_schedulability_sim
   import fps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [31:0] per_mem [MaxTasks];
   logic [31:0] exe_mem [MaxTasks];
   logic [31:0] dl_mem  [MaxTasks];
   logic [31:0] el_mem  [MaxTasks];
   logic [31:0] sl_mem  [MaxTasks];
   logic [31:0] rc_mem  [MaxTasks];

   state_type state_ff, state_in;
   logic [1:0]  mode_ff;
   logic [31:0] horizon_ff;
   logic [CntBits-1:0] count_ff, count_in;
   logic [IdxBits-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [31:0] now_ff, now_in, step_ff, step_in;
   logic        found_ff, found_in, ok_ff, ok_in;
   logic [IdxBits-1:0] run_ff, run_in;
   logic [63:0] prod_a_ff, prod_in;
   logic        mul_sel_ff, mul_sel_in;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   // shared multiplier operands
   logic [31:0] mul_x, mul_y;
   logic [63:0] mul_p;
   assign mul_p = {32'd0, mul_x} * {32'd0, mul_y};

   logic req_acc;
   assign req_acc = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_LOAD);

   logic csr_wr;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   always_comb begin
      unique case (csr_paddr[2])
         RegMode:    csr_prdata = {30'd0, mode_ff};
         RegHorizon: csr_prdata = horizon_ff;
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ModePeriod;
         horizon_ff <= 32'd100000;
      end else if (csr_wr) begin
         if (csr_paddr[2] == RegMode) mode_ff <= csr_pwdata[1:0];
         else horizon_ff <= csr_pwdata;
      end
   end

   logic [IdxBits-1:0] jm1;
   assign jm1 = j_ff - 1'b1;
   logic [31:0] rc_dec;
   assign rc_dec = rc_mem[k_ff] - step_ff;
   logic [31:0] el_k;
   assign el_k = (found_ff && run_ff == k_ff) ? el_mem[k_ff] - step_ff : el_mem[k_ff];
   logic [IdxBits-1:0] last_idx;
   assign last_idx = IdxBits'(count_ff - 1'b1);
   logic outrank;

   always_comb begin
      state_in = state_ff; count_in = count_ff; i_in = i_ff; j_in = j_ff; k_in = k_ff;
      now_in = now_ff; step_in = step_ff; found_in = found_ff; run_in = run_ff;
      ok_in = ok_ff; prod_in = prod_a_ff; mul_sel_in = mul_sel_ff;
      mul_x = mul_sel_ff ? exe_mem[jm1] : exe_mem[j_ff];
      mul_y = mul_sel_ff ? per_mem[j_ff] : per_mem[jm1];
      outrank = 1'b0;
      unique case (mode_ff)
         ModeLoad:   outrank = 1'b0;
         ModePeriod: outrank = per_mem[j_ff] < per_mem[jm1];
         ModeExec:   outrank = exe_mem[j_ff] < exe_mem[jm1];
         ModeUtil:   outrank = prod_a_ff > mul_p;
         default:    outrank = 1'b0;
      endcase
      unique case (state_ff)
         ST_LOAD: begin
            if (req_acc) begin
               if (count_ff < CntBits'(MaxTasks)) count_in = count_ff + 1'b1;
               if (req_data.last_task) begin
                  state_in = ST_SORT_RD;
                  i_in = IdxBits'(1);
                  j_in = IdxBits'(1);
               end
            end
         end
         ST_SORT_RD: begin
            // count here already includes the final item
            if ({1'b0, i_ff} >= count_ff || i_ff == '0) state_in = ST_INIT;
            else if (j_ff == '0) begin
               i_in = i_ff + 1'b1; j_in = i_ff + 1'b1;
               if (i_ff == IdxBits'(MaxTasks - 1)) state_in = ST_INIT;
            end else if (mode_ff == ModeUtil) begin
               mul_sel_in = 1'b0; state_in = ST_SORT_MUL;
            end else state_in = ST_SORT_CMP;
         end
         ST_SORT_MUL: begin
            prod_in = mul_p; mul_sel_in = 1'b1; state_in = ST_SORT_CMP;
         end
         ST_SORT_CMP: begin
            if (outrank) j_in = jm1;
            else j_in = '0;
            state_in = ST_SORT_RD;
         end
         ST_INIT: begin
            now_in = '0; k_in = '0; ok_in = 1'b1;
            state_in = ST_PICK; step_in = TimeMax; found_in = 1'b0;
         end
         ST_PICK: begin
            if (k_ff == '0 && !(now_ff < horizon_ff && now_ff < TimeMax)) begin
               state_in = ST_DONE;
            end else begin
               if (!found_ff && el_mem[k_ff] != '0) begin
                  found_in = 1'b1; run_in = k_ff;
               end
               if (rc_mem[k_ff] < step_ff) step_in = rc_mem[k_ff];
               if (k_ff == last_idx) state_in = ST_RUN;
               else k_in = k_ff + 1'b1;
            end
         end
         ST_RUN: begin
            if (found_ff && el_mem[run_ff] < step_ff) step_in = el_mem[run_ff];
            k_in = '0; state_in = ST_UPD;
         end
         ST_UPD: begin
            if ((sl_mem[k_ff] != '0 && el_k != '0 && sl_mem[k_ff] <= step_ff)
                || k_ff == last_idx) begin
               now_in = (TimeMax - now_ff < step_ff) ? TimeMax : now_ff + step_ff;
               if (sl_mem[k_ff] != '0 && el_k != '0 && sl_mem[k_ff] <= step_ff) begin
                  ok_in = 1'b0; state_in = ST_DONE;
               end else begin
                  state_in = ST_PICK;
               end
               k_in = '0; step_in = TimeMax; found_in = 1'b0;
            end else k_in = k_ff + 1'b1;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_LOAD; count_in = '0;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (state_ff == ST_DONE && (!rsp_valid_ff || !rsp_stall)) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in; j_ff <= j_in; k_ff <= k_in; now_ff <= now_in; step_ff <= step_in;
      found_ff <= found_in; run_ff <= run_in; ok_ff <= ok_in;
      prod_a_ff <= prod_in; mul_sel_ff <= mul_sel_in;
      if (state_ff == ST_DONE && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_ff.schedulable <= ok_ff;
         rsp_ff.end_time <= now_ff;
      end
   end

   // table writes: load, sort swaps, run-table init, run-time updates
   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD && req_acc && count_ff < CntBits'(MaxTasks)) begin
         per_mem[count_ff[IdxBits-1:0]] <= (req_data.task_period == '0) ? 32'd1
                                                                           : req_data.task_period;
         exe_mem[count_ff[IdxBits-1:0]] <= req_data.task_exec_time;
         dl_mem[count_ff[IdxBits-1:0]] <= req_data.task_deadline;
      end
      if (state_ff == ST_SORT_CMP && outrank) begin
         per_mem[j_ff] <= per_mem[jm1]; per_mem[jm1] <= per_mem[j_ff];
         exe_mem[j_ff] <= exe_mem[jm1]; exe_mem[jm1] <= exe_mem[j_ff];
         dl_mem[j_ff] <= dl_mem[jm1]; dl_mem[jm1] <= dl_mem[j_ff];
      end
      if (state_ff == ST_INIT) begin
         for (int t = 0; t < MaxTasks; t++) begin
            el_mem[t] <= exe_mem[t]; sl_mem[t] <= dl_mem[t]; rc_mem[t] <= per_mem[t];
         end
      end
      if (state_ff == ST_UPD) begin
         if (sl_mem[k_ff] != '0 && el_k != '0 && sl_mem[k_ff] <= step_ff) begin
            sl_mem[k_ff] <= '0;
            el_mem[k_ff] <= el_k;
         end else if (rc_dec == '0) begin
            el_mem[k_ff] <= exe_mem[k_ff];
            sl_mem[k_ff] <= dl_mem[k_ff];
            rc_mem[k_ff] <= per_mem[k_ff];
         end else begin
            if (sl_mem[k_ff] != '0 && el_k != '0) sl_mem[k_ff] <= sl_mem[k_ff] - step_ff;
            el_mem[k_ff] <= el_k;
            rc_mem[k_ff] <= rc_dec;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");
   a_load_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntBits'(MaxTasks)) else $error("task count overflow");
   a_fail_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !ok_ff) |-> $past(state_ff) == ST_UPD || $past(state_ff) == ST_DONE)
      else $error("miss reported outside update");
endmodule

FILE: sim/tb_fixed_priority_schedulability_sim.sv
// Self-checking testbench of the fixed-priority schedulability simulator.
`timescale 1ns / 100ps

module tb_fixed_priority_schedulability_sim;
   import fps_pkg::*;

   localparam longint unsigned TimeTop = 64'h0000_0000_FFFF_FFFF;
   localparam int CycleLimit = 20000000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   fixed_priority_schedulability_sim uut (.*);

   // predictor state
   logic [1:0]      model_mode;
   longint unsigned model_horizon;
   longint unsigned set_period [MaxTasks];
   longint unsigned set_exec [MaxTasks];
   longint unsigned set_deadline [MaxTasks];
   int              set_count;

   req_type pending_items [$];
   rsp_type expected_verdicts [$];
   int      error_count;
   int      cycle_count;
   logic    req_taken;
   int      burst_left;
   int      gap_left;
   int      stall_mode;
   int      stall_timer;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic outranks(int a, int b);
      case (model_mode)
         ModePeriod: return set_period[a] < set_period[b];
         ModeExec: return set_exec[a] < set_exec[b];
         ModeUtil: return set_exec[a] * set_period[b] > set_exec[b] * set_period[a];
         default: return 1'b0;
      endcase
   endfunction

   // Sort the held set by priority, then simulate it; returns the verdict.
   task automatic schedule_set(output rsp_type verdict);
      longint unsigned run_left [MaxTasks];
      longint unsigned slack [MaxTasks];
      longint unsigned countdown [MaxTasks];
      longint unsigned now;
      longint unsigned span;
      longint unsigned tmp;
      int   run;
      logic missed;
      for (int i = 1; i < set_count; i++) begin
         for (int j = i; j > 0 && outranks(j, j - 1); j--) begin
            tmp = set_period[j]; set_period[j] = set_period[j-1]; set_period[j-1] = tmp;
            tmp = set_exec[j]; set_exec[j] = set_exec[j-1]; set_exec[j-1] = tmp;
            tmp = set_deadline[j]; set_deadline[j] = set_deadline[j-1];
            set_deadline[j-1] = tmp;
         end
      end
      for (int i = 0; i < set_count; i++) begin
         run_left[i] = set_exec[i];
         slack[i] = set_deadline[i];
         countdown[i] = set_period[i];
      end
      now = 0;
      missed = 1'b0;
      while (!missed && now < model_horizon && now < TimeTop) begin
         span = TimeTop;
         run = -1;
         for (int i = 0; i < set_count; i++)
            if (run < 0 && run_left[i] != 0) run = i;
         for (int i = 0; i < set_count; i++)
            if (countdown[i] < span) span = countdown[i];
         if (run >= 0) begin
            if (run_left[run] < span) span = run_left[run];
            run_left[run] -= span;
         end
         for (int i = 0; i < set_count && !missed; i++) begin
            if (slack[i] != 0 && run_left[i] != 0) begin
               if (slack[i] <= span) missed = 1'b1;
               else slack[i] -= span;
            end
            if (!missed) begin
               countdown[i] -= span;
               if (countdown[i] == 0) begin
                  run_left[i] = set_exec[i];
                  slack[i] = set_deadline[i];
                  countdown[i] = set_period[i];
               end
            end
         end
         now = (TimeTop - now < span) ? TimeTop : now + span;
      end
      verdict.schedulable = !missed;
      verdict.end_time = now[31:0];
   endtask

   task automatic load_task(input req_type item);
      rsp_type verdict;
      if (set_count < MaxTasks) begin
         set_period[set_count] = (item.task_period == 0) ? 64'd1 : 64'(item.task_period);
         set_exec[set_count] = 64'(item.task_exec_time);
         set_deadline[set_count] = 64'(item.task_deadline);
         set_count++;
      end
      if (item.last_task) begin
         schedule_set(verdict);
         expected_verdicts = {expected_verdicts, verdict};
         set_count = 0;
      end
   endtask

   // input side: bursts with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold the stalled item
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending_items.size() > 0) begin
         req_data <= pending_items.pop_front();
         req_valid <= 1'b1;
         if (burst_left == 0) begin
            burst_left <= $urandom_range(0, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result side stall pattern: none, random, or long runs
   always @(negedge clock) begin
      if (stall_timer == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_timer <= $urandom_range(50, 400);
      end else begin
         stall_timer <= stall_timer - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom_range(0, 1));
         default: rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   always @(posedge clock) begin
      rsp_type want;
      req_taken <= 1'b0;
      if (!reset) begin
         cycle_count <= cycle_count + 1;
         if (req_valid && !req_stall) begin
            req_taken <= 1'b1;
            load_task(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_data);
               error_count++;
            end else begin
               want = expected_verdicts.pop_front();
               if (want.schedulable !== rsp_data.schedulable) begin
                  $display("%0t: schedulable expected %b actual %b", $time,
                           want.schedulable, rsp_data.schedulable);
                  error_count++;
               end
               if (want.end_time !== rsp_data.end_time) begin
                  $display("%0t: end_time expected %0d actual %0d", $time,
                           want.end_time, rsp_data.end_time);
                  error_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count >= CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic csr_write(input logic [0:0] index, input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_items.size() > 0 || req_valid || expected_verdicts.size() > 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // Drain the block, then switch its settings.
   task automatic set_phase(input logic [1:0] mode, input logic [31:0] horizon);
      wait_drained();
      csr_write(RegMode, {30'd0, mode});
      csr_write(RegHorizon, horizon);
      model_mode = mode;
      model_horizon = 64'(horizon);
   endtask

   task automatic add_task(input logic [31:0] period, input logic [31:0] exec_time,
                           input logic [31:0] deadline, input logic last);
      req_type item;
      item.task_period = period;
      item.task_exec_time = exec_time;
      item.task_deadline = deadline;
      item.last_task = last;
      pending_items = {pending_items, item};
   endtask

   // Mostly well-formed periodic tasks, with some fully random noise.
   task automatic add_random_set(inout int items);
      int          n;
      logic [31:0] p;
      logic [31:0] e;
      logic [31:0] d;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 18) : $urandom_range(1, 6);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 9) == 0) begin
            p = $urandom;
            e = $urandom;
            d = $urandom;
         end else begin
            p = $urandom_range(50, 400);
            e = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, p / n + 10);
            d = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(e / 2, p + 50);
         end
         add_task(p, e, d, k == n - 1);
         items++;
      end
   endtask

   initial begin
      int items;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      model_mode = ModePeriod;
      model_horizon = 100000;
      set_count = 0;
      error_count = 0;
      cycle_count = 0;
      burst_left = 0;
      gap_left = 0;
      stall_mode = 0;
      stall_timer = 0;
      req_taken = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: a harmonic set
      add_task(100, 20, 100, 1'b0);
      add_task(200, 50, 200, 1'b1);
      set_phase(ModePeriod, 0);
      add_task(5, 3, 5, 1'b1);
      set_phase(ModeLoad, 1);
      add_task(0, 0, 0, 1'b1);
      set_phase(ModeExec, 1000);
      add_task(0, 3, 0, 1'b1);
      add_task(10, 8, 5, 1'b1);
      add_task(10, 20, 0, 1'b1);
      add_task(60, 5, 60, 1'b0);
      add_task(40, 0, 40, 1'b0);
      add_task(20, 30, 15, 1'b1);
      set_phase(ModeUtil, 2000);
      for (int k = 0; k < 18; k++)
         add_task(100 + k, 1 + k % 3, 100, k == 17);
      set_phase(ModeUtil, 32'hFFFF_FFFF);
      add_task(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      add_task(32'h8000_0000, 1, 32'h7FFF_FFFF, 1'b0);
      add_task(32'hFFFF_FFFE, 32'h4000_0000, 32'hFFFF_FFFF, 1'b1);

      for (int phase = 0; phase < 8; phase++) begin
         set_phase(2'(phase % 4), $urandom_range(200, 1500));
         items = 0;
         while (items < 66) add_random_set(items);
      end

      wait_drained();
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

FILE: sim.f
hdl/fps_pkg.sv
hdl/fixed_priority_schedulability_sim.sv
sim/tb_fixed_priority_schedulability_sim.sv
